// ===== sv/color_gradient_lookup_defines.svh =====
// assertion macros for the color gradient lookup
`ifndef COLOR_GRADIENT_LOOKUP_DEFINES_SVH
`define COLOR_GRADIENT_LOOKUP_DEFINES_SVH
// implication checked on every clock, idle during reset
`define CGL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication
`define CGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== sv/cgl_pkg.sv =====
// ---------------------------------------------------------------------------
// cgl_pkg
// shared types and constants of the color gradient lookup
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cgl_pkg;
  localparam int MAX_STOPS     = 16;
  localparam int IDX_W         = $clog2(MAX_STOPS);
  localparam int CNT_W         = $clog2(MAX_STOPS + 1);
  localparam int CHANNEL_BITS  = 16;
  localparam int FRACTION_BITS = 16;
  localparam int POS_W         = 17;
  localparam logic [POS_W-1:0] POS_ONE = 17'h10000;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0, FUNC_SET_FIRST = 2'd1, FUNC_SET_LAST = 2'd2, FUNC_LOOKUP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_RANGE = 2'd1, ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_WRITE, S_LREAD, S_DIV, S_LERP_A, S_LERP_B, S_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== sv/cgl_div.sv =====
// ---------------------------------------------------------------------------
// cgl_div
// restoring radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "color_gradient_lookup_defines.svh"
module cgl_div (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  input  wire logic [cgl_pkg::POS_W-1:0]             num_hi,
  input  wire logic [cgl_pkg::POS_W-1:0]             den,
  output logic                                       busy,
  output logic [cgl_pkg::FRACTION_BITS-1:0]          quo
);
  localparam int QW = cgl_pkg::FRACTION_BITS;
  localparam int CW = $clog2(QW + 1);
  // remainder starts as numerator high part; numerator low part is zero
  logic [cgl_pkg::POS_W:0]       rem_r, rem_nxt;
  logic [cgl_pkg::POS_W-1:0]     den_r;
  logic [QW-1:0]                 quo_r, quo_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [cgl_pkg::POS_W+1:0]     trial;

  always_comb begin
    trial   = {rem_r, 1'b0} - {2'b00, den_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = {1'b0, num_hi};
      quo_nxt = '0;
      cnt_nxt = CW'(QW);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[cgl_pkg::POS_W+1]) begin
        rem_nxt = trial[cgl_pkg::POS_W:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[cgl_pkg::POS_W-1:0], 1'b0};
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

  `CGL_ASSERT_NEXT(a_div_load, clk, rst_n, start, cnt_r == CW'(QW))
  `CGL_ASSERT_IMP(a_div_rem, clk, rst_n, busy, rem_r < {1'b0, den_r})
  `CGL_ASSERT_NEXT(a_div_count, clk, rst_n, busy && !start, cnt_r == $past(cnt_r) - 1'b1)
endmodule
`default_nettype wire

// ===== sv/color_gradient_lookup.sv =====
// insert runs a serial search, then moves the stops above the slot up one by one;
// rejected insert and recolor go straight to the result; lookup runs the serial search,
// a divide and 8 shared multiplier passes; on the last stop it ends after the search
// throughput: one request at a time; busy stays high through the result strobe
// the receiver cannot stall: out_valid marks each result for one cycle
// reset: two stops, black at 0.0 and white at 1.0
// ---------------------------------------------------------------------------
// color_gradient_lookup
// sorted color stop table with serial search, divide and interpolation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "color_gradient_lookup_defines.svh"
module color_gradient_lookup (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [16:0] in_point,
  input  wire logic [15:0] in_red,
  input  wire logic [15:0] in_green,
  input  wire logic [15:0] in_blue,
  input  wire logic [15:0] in_alpha,
  output logic             out_valid,
  output logic [15:0]      out_red,
  output logic [15:0]      out_green,
  output logic [15:0]      out_blue,
  output logic [15:0]      out_alpha,
  output logic [1:0]       out_status
);
  localparam int N  = cgl_pkg::MAX_STOPS;
  localparam int IW = cgl_pkg::IDX_W;
  localparam int CW = cgl_pkg::CNT_W;
  localparam int PW = cgl_pkg::POS_W;
  localparam int FB = cgl_pkg::FRACTION_BITS;

  // stop table, regs (small, read at fixed index per cycle via counter)
  logic [PW-1:0] pos_r [N];
  logic [63:0]   col_r [N];
  logic [CW-1:0] cnt_r;

  cgl_pkg::state_t state_r, state_nxt;
  cgl_pkg::func_t  func_r;
  logic [PW-1:0]   pt_r;
  logic [63:0]     cin_r;
  logic [CW-1:0]   idx_r;             // search / shift pointer
  logic [CW-1:0]   at_r;
  logic [PW-1:0]   p1_r;
  logic [63:0]     c1_r, c2_r;
  logic [1:0]      ch_r;              // channel under interpolation
  logic [63:0]     res_r;
  logic [1:0]      st_r;
  logic [FB:0]     f_r;
  logic [FB+16:0]  acc_r;
  logic            ovalid_r;

  logic            div_start;
  logic            div_busy;
  logic [FB-1:0]   quo;
  logic [PW-1:0]   div_num, div_den;

  // request taken only while idle and no result is on the ports
  logic req_accept;
  assign req_accept = start && !busy;

  // shared multiplier: one 17x16 product per cycle
  logic [15:0]    m_a;
  logic [FB:0]    m_b;
  logic [FB+16:0] m_p;
  assign m_p = (FB+17)'(m_a) * (FB+17)'(m_b);

  logic [IW-1:0] idx_i, idxm1_i;
  assign idx_i   = idx_r[IW-1:0];
  assign idxm1_i = IW'(idx_r - 1'b1);

  // raw request point, clamped on capture for lookups
  logic [PW-1:0] pt_in;
  assign pt_in = in_point;

  cgl_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_hi(div_num), .den(div_den), .busy(div_busy), .quo(quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cgl_pkg::S_IDLE: if (req_accept) begin
        unique case (cgl_pkg::func_t'(in_func))
          cgl_pkg::FUNC_INSERT: state_nxt =
            (pt_in > cgl_pkg::POS_ONE || cnt_r >= CW'(N)) ? cgl_pkg::S_DONE
                                                          : cgl_pkg::S_SEARCH;
          cgl_pkg::FUNC_LOOKUP: state_nxt = cgl_pkg::S_SEARCH;
          default:              state_nxt = cgl_pkg::S_DONE;
        endcase
      end
      cgl_pkg::S_SEARCH: begin
        if (idx_r >= cnt_r)
          state_nxt = (func_r == cgl_pkg::FUNC_INSERT) ? cgl_pkg::S_SHIFT
                                                       : cgl_pkg::S_DONE;
        else if (pos_r[idx_i] > pt_r)
          state_nxt = (func_r == cgl_pkg::FUNC_INSERT) ? cgl_pkg::S_SHIFT
                                                       : cgl_pkg::S_LREAD;
      end
      cgl_pkg::S_SHIFT:  if (idx_r == at_r) state_nxt = cgl_pkg::S_DONE;
      cgl_pkg::S_LREAD:  state_nxt = cgl_pkg::S_DIV;
      cgl_pkg::S_DIV:    if (!div_busy && !div_start) state_nxt = cgl_pkg::S_LERP_A;
      cgl_pkg::S_LERP_A: state_nxt = cgl_pkg::S_LERP_B;
      cgl_pkg::S_LERP_B: if (ch_r == 2'd3) state_nxt = cgl_pkg::S_DONE;
                         else state_nxt = cgl_pkg::S_LERP_A;
      cgl_pkg::S_DONE:   state_nxt = cgl_pkg::S_IDLE;
      default:           state_nxt = cgl_pkg::S_IDLE;
    endcase
  end

  // datapath outputs of the sequencer
  always_comb begin
    div_start = (state_r == cgl_pkg::S_LREAD);
    div_num   = pt_r - p1_r;
    div_den   = pos_r[idx_i] - p1_r;
    m_a       = 16'(c1_r >> (16 * ch_r));
    m_b       = (FB+1)'(1 << FB) - f_r;
    if (state_r == cgl_pkg::S_LERP_B) begin
      m_a = 16'(c2_r >> (16 * ch_r));
      m_b = f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cgl_pkg::S_IDLE;
      cnt_r    <= CW'(2);
      ovalid_r <= 1'b0;
      idx_r    <= '0;
      pos_r[0] <= '0;
      pos_r[1] <= cgl_pkg::POS_ONE;
      col_r[0] <= 64'hFFFF_0000_0000_0000;
      col_r[1] <= '1;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= (state_r == cgl_pkg::S_DONE);
      unique case (state_r)
        cgl_pkg::S_IDLE: if (req_accept) begin
          func_r <= cgl_pkg::func_t'(in_func);
          cin_r  <= {in_alpha, in_blue, in_green, in_red};
          pt_r   <= (in_func == cgl_pkg::FUNC_LOOKUP && pt_in > cgl_pkg::POS_ONE)
                    ? cgl_pkg::POS_ONE : pt_in;
          idx_r  <= (in_func == cgl_pkg::FUNC_LOOKUP) ? CW'(1) : '0;
          st_r   <= cgl_pkg::ST_OK;
          res_r  <= {in_alpha, in_blue, in_green, in_red};
          if (in_func == cgl_pkg::FUNC_INSERT && pt_in > cgl_pkg::POS_ONE) begin
            st_r <= cgl_pkg::ST_RANGE; res_r <= '0;
          end else if (in_func == cgl_pkg::FUNC_INSERT && cnt_r >= CW'(N)) begin
            st_r <= cgl_pkg::ST_FULL; res_r <= '0;
          end else if (in_func == cgl_pkg::FUNC_SET_FIRST) begin
            col_r[0] <= {in_alpha, in_blue, in_green, in_red};
          end else if (in_func == cgl_pkg::FUNC_SET_LAST) begin
            col_r[IW'(cnt_r - 1'b1)] <= {in_alpha, in_blue, in_green, in_red};
          end
        end
        cgl_pkg::S_SEARCH: begin
          if (idx_r >= cnt_r) begin
            at_r  <= cnt_r;
            idx_r <= cnt_r;
            if (func_r == cgl_pkg::FUNC_LOOKUP) res_r <= col_r[IW'(cnt_r - 1'b1)];
          end else if (pos_r[idx_i] > pt_r) begin
            at_r  <= idx_r;
            idx_r <= (func_r == cgl_pkg::FUNC_INSERT) ? cnt_r : idx_r;
            p1_r  <= pos_r[idxm1_i];
            c1_r  <= col_r[idxm1_i];
            c2_r  <= col_r[idx_i];
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        cgl_pkg::S_SHIFT: begin
          // move one entry up per cycle, then drop the new stop in
          if (idx_r == at_r) begin
            pos_r[idx_i] <= pt_r;
            col_r[idx_i] <= cin_r;
            cnt_r        <= cnt_r + 1'b1;
          end else begin
            pos_r[idx_i] <= pos_r[idxm1_i];
            col_r[idx_i] <= col_r[idxm1_i];
            idx_r        <= idx_r - 1'b1;
          end
        end
        cgl_pkg::S_LREAD: ch_r <= '0;
        cgl_pkg::S_DIV: f_r <= {1'b0, quo};
        cgl_pkg::S_LERP_A: acc_r <= m_p + (FB+17)'(1 << (FB - 1));
        cgl_pkg::S_LERP_B: begin
          res_r[16*ch_r +: 16] <= 16'((acc_r + m_p) >> FB);
          ch_r <= ch_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign busy       = (state_r != cgl_pkg::S_IDLE) || ovalid_r;
  assign out_valid  = ovalid_r;
  assign out_red    = res_r[15:0];
  assign out_green  = res_r[31:16];
  assign out_blue   = res_r[47:32];
  assign out_alpha  = res_r[63:48];
  assign out_status = st_r;

  `CGL_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r >= CW'(2) && cnt_r <= CW'(N))
  `CGL_ASSERT_NEXT(a_done_valid, clk, rst_n, state_r == cgl_pkg::S_DONE, out_valid)
  `CGL_ASSERT_IMP(a_ends_fixed, clk, rst_n, 1'b1, pos_r[0] == '0)
endmodule
`default_nettype wire

// ===== tb/sv/color_gradient_lookup_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// color_gradient_lookup_tb
// checks the gradient stop table against a behavioral model of its own:
// a directed table of requests, then random requests with random gaps
// ---------------------------------------------------------------------------
module color_gradient_lookup_tb;

  localparam int RANDOM_REQS = 1400;
  localparam longint CYCLE_LIMIT = 2000000;

  // one row of the directed table; has_exp marks rows with a typed-in answer
  typedef struct {
    cgl_pkg::func_t   func;
    logic [16:0]      point;
    logic [15:0]      red, green, blue, alpha;
    logic             has_exp;
    logic [15:0]      e_red, e_green, e_blue, e_alpha;
    cgl_pkg::status_t e_status;
  } req_row_t;

  typedef struct packed {
    logic [15:0]      red, green, blue, alpha;
    cgl_pkg::status_t status;
  } color_res_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [16:0] in_point;
  logic [15:0] in_red, in_green, in_blue, in_alpha;
  logic        out_valid;
  logic [15:0] out_red, out_green, out_blue, out_alpha;
  logic [1:0]  out_status;

  color_gradient_lookup u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_point(in_point),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_alpha(out_alpha), .out_status(out_status)
  );

  // model copy of the stop table
  logic [16:0] grad_pos [cgl_pkg::MAX_STOPS];
  logic [63:0] grad_col [cgl_pkg::MAX_STOPS];
  int          grad_count;

  color_res_t  pending_colors [$];
  int          fail_count;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void reset_gradient();
    for (int i = 0; i < cgl_pkg::MAX_STOPS; i++) begin
      grad_pos[i] = '0;
      grad_col[i] = '0;
    end
    grad_pos[1] = cgl_pkg::POS_ONE;
    grad_col[0] = 64'hFFFF_0000_0000_0000;
    grad_col[1] = '1;
    grad_count  = 2;
  endfunction

  function automatic color_res_t pack_res(logic [63:0] c, cgl_pkg::status_t st);
    color_res_t r;
    r.red   = c[15:0];
    r.green = c[31:16];
    r.blue  = c[47:32];
    r.alpha = c[63:48];
    r.status = st;
    return r;
  endfunction

  // blend two stop colors with a 17-bit fraction of 16 fraction bits, rounded
  function automatic logic [63:0] blend(logic [63:0] c1, logic [63:0] c2,
                                        logic [16:0] f);
    logic [63:0] res;
    logic [40:0] acc;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      acc = 41'(c1[16*k +: 16]) * (41'(1 << cgl_pkg::FRACTION_BITS) - 41'(f))
          + 41'(c2[16*k +: 16]) * 41'(f) + 41'(1 << (cgl_pkg::FRACTION_BITS - 1));
      res[16*k +: 16] = acc[cgl_pkg::FRACTION_BITS +: 16];
    end
    return res;
  endfunction

  // apply one request to the model table and return its answer
  function automatic color_res_t gradient_step(cgl_pkg::func_t f, logic [16:0] p,
                                               logic [63:0] c);
    int at;
    logic [16:0] t;
    logic [33:0] num;
    logic [16:0] frac;
    case (f)
      cgl_pkg::FUNC_INSERT: begin
        if (p > cgl_pkg::POS_ONE) return pack_res('0, cgl_pkg::ST_RANGE);
        if (grad_count >= cgl_pkg::MAX_STOPS) return pack_res('0, cgl_pkg::ST_FULL);
        at = grad_count;
        for (int i = grad_count - 1; i >= 0; i--)
          if (grad_pos[i] > p) at = i;
        for (int i = grad_count; i > at; i--) begin
          grad_pos[i] = grad_pos[i-1];
          grad_col[i] = grad_col[i-1];
        end
        grad_pos[at] = p;
        grad_col[at] = c;
        grad_count++;
        return pack_res(c, cgl_pkg::ST_OK);
      end
      cgl_pkg::FUNC_SET_FIRST: begin
        grad_col[0] = c;
        return pack_res(c, cgl_pkg::ST_OK);
      end
      cgl_pkg::FUNC_SET_LAST: begin
        grad_col[grad_count-1] = c;
        return pack_res(c, cgl_pkg::ST_OK);
      end
      default: begin
        t = (p > cgl_pkg::POS_ONE) ? cgl_pkg::POS_ONE : p;
        for (int i = 1; i < grad_count; i++) begin
          if (grad_pos[i] > t) begin
            if (t < grad_pos[i-1]) t = grad_pos[i-1];
            num = 34'(t - grad_pos[i-1]) << cgl_pkg::FRACTION_BITS;
            frac = 17'(num / 34'(grad_pos[i] - grad_pos[i-1]));
            return pack_res(blend(grad_col[i-1], grad_col[i], frac), cgl_pkg::ST_OK);
          end
        end
        // point at the last position returns the last color
        return pack_res(grad_col[grad_count-1], cgl_pkg::ST_OK);
      end
    endcase
  endfunction

  // result checker: every strobe pops the oldest expectation
  always @(posedge clk) begin
    color_res_t e;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        $display("%0t: unexpected result r=%h g=%h b=%h a=%h st=%0d", $time,
                 out_red, out_green, out_blue, out_alpha, out_status);
        fail_count++;
      end else begin
        e = pending_colors.pop_front();
        if (out_red !== e.red) begin
          $display("%0t: red exp %h got %h", $time, e.red, out_red);
          fail_count++;
        end
        if (out_green !== e.green) begin
          $display("%0t: green exp %h got %h", $time, e.green, out_green);
          fail_count++;
        end
        if (out_blue !== e.blue) begin
          $display("%0t: blue exp %h got %h", $time, e.blue, out_blue);
          fail_count++;
        end
        if (out_alpha !== e.alpha) begin
          $display("%0t: alpha exp %h got %h", $time, e.alpha, out_alpha);
          fail_count++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_status);
          fail_count++;
        end
      end
    end
  end

  // issue one request: wait for idle, start stays up until a gap drops it
  task automatic issue_request(cgl_pkg::func_t f, logic [16:0] p, logic [63:0] c,
                               logic has_exp, color_res_t typed);
    color_res_t e;
    start    <= 1'b1;
    in_func  <= f;
    in_point <= p;
    in_red   <= c[15:0];
    in_green <= c[31:16];
    in_blue  <= c[47:32];
    in_alpha <= c[63:48];
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge; expectation lands before any result strobe
    e = gradient_step(f, p, c);
    if (has_exp && e != typed) begin
      $display("%0t: table row disagrees with model", $time);
      fail_count++;
    end
    if (has_exp) e = typed;
    pending_colors = {pending_colors, e};
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_point();
    case ($urandom_range(0, 9))
      0: return cgl_pkg::POS_ONE;
      1: return 17'd0;
      2: return 17'($urandom_range(65537, 131071));
      3: return grad_pos[$urandom_range(0, grad_count - 1)];
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [63:0] rand_color();
    return {$urandom(), $urandom()};
  endfunction

  req_row_t directed [$];

  function automatic void add_row(req_row_t r);
    directed = {directed, r};
  endfunction

  function automatic req_row_t row(cgl_pkg::func_t f, logic [16:0] p, logic [63:0] c,
                                   logic has_exp, logic [63:0] ec,
                                   cgl_pkg::status_t es);
    req_row_t r;
    r.func = f; r.point = p;
    r.red = c[15:0]; r.green = c[31:16]; r.blue = c[47:32]; r.alpha = c[63:48];
    r.has_exp = has_exp;
    r.e_red = ec[15:0]; r.e_green = ec[31:16]; r.e_blue = ec[47:32];
    r.e_alpha = ec[63:48]; r.e_status = es;
    return r;
  endfunction

  initial begin
    color_res_t typed;
    int settle;
    fail_count  = 0;
    cycle_count = 0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_func  = cgl_pkg::FUNC_INSERT;
    in_point = '0;
    in_red   = '0;
    in_green = '0;
    in_blue  = '0;
    in_alpha = '0;
    typed    = '0;
    reset_gradient();

    // directed table: reset colors, extremes, errors, equal positions
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'd0, '0, 1'b1, 64'hFFFF_0000_0000_0000,
                cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, cgl_pkg::POS_ONE, '0, 1'b1, '1, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'h1FFFF, '0, 1'b1, '1, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'h08000, '0, 1'b0, '0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h10001, '1, 1'b1, '0, cgl_pkg::ST_RANGE));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h1FFFF, '1, 1'b1, '0, cgl_pkg::ST_RANGE));
    add_row(row(cgl_pkg::FUNC_SET_FIRST, 17'h1FFFF, 64'h1234_5678_9ABC_DEF0, 1'b1,
                64'h1234_5678_9ABC_DEF0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_SET_LAST, 17'd0, 64'h0F0F_F0F0_AAAA_5555, 1'b1,
                64'h0F0F_F0F0_AAAA_5555, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h08000, 64'hFFFF_0000_FFFF_0000, 1'b1,
                64'hFFFF_0000_FFFF_0000, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h08000, 64'h0000_FFFF_0000_FFFF, 1'b1,
                64'h0000_FFFF_0000_FFFF, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'h08000, '0, 1'b0, '0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'd0, 64'h1111_2222_3333_4444, 1'b1,
                64'h1111_2222_3333_4444, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, cgl_pkg::POS_ONE, 64'h5555_6666_7777_8888, 1'b1,
                64'h5555_6666_7777_8888, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'd0, '0, 1'b0, '0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, cgl_pkg::POS_ONE, '0, 1'b1, 64'h5555_6666_7777_8888,
                cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'h04000, '0, 1'b0, '0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_LOOKUP, 17'h0FFFF, '0, 1'b0, '0, cgl_pkg::ST_OK));
    // fill the table to the brim, then one more is refused
    for (int i = 0; i < 10; i++)
      add_row(row(cgl_pkg::FUNC_INSERT, 17'(i * 6000 + 1),
                  64'(i) * 64'h0101_0101_0101_0101, 1'b0, '0, cgl_pkg::ST_OK));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h00100, '1, 1'b1, '0, cgl_pkg::ST_FULL));
    add_row(row(cgl_pkg::FUNC_INSERT, 17'h10001, '1, 1'b1, '0, cgl_pkg::ST_RANGE));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      typed.red = directed[i].e_red; typed.green = directed[i].e_green;
      typed.blue = directed[i].e_blue; typed.alpha = directed[i].e_alpha;
      typed.status = directed[i].e_status;
      issue_request(directed[i].func, directed[i].point,
                    {directed[i].alpha, directed[i].blue, directed[i].green, directed[i].red},
                    directed[i].has_exp, typed);
      if (i % 4 == 3) idle_gap();
    end

    // random part: the table is already full, so inserts are refused; lookups dominate
    for (int n = 0; n < RANDOM_REQS; n++) begin
      cgl_pkg::func_t f;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) f = cgl_pkg::FUNC_INSERT;
      else if (pick < 32) f = cgl_pkg::FUNC_SET_FIRST;
      else if (pick < 39) f = cgl_pkg::FUNC_SET_LAST;
      else f = cgl_pkg::FUNC_LOOKUP;
      issue_request(f, rand_point(), rand_color(), 1'b0, typed);
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
    start <= 1'b0;

    // wait until everything is back, then let trailing cycles pass
    while (pending_colors.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 100) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/cgl_pkg.sv
sv/cgl_div.sv
sv/color_gradient_lookup.sv
tb/sv/color_gradient_lookup_tb.sv
